### design/lmfe_pkg.sv
`timescale 1ns / 1ps

package lmfe_pkg;

    localparam int          RX_BYTES_DEF     = 5;
    localparam int          MAX_RES          = 4;
    localparam int          RES_IDX_W        = $clog2(MAX_RES);
    localparam int          RES_CNT_W        = $clog2(MAX_RES + 1);

    localparam logic [2:0]  MAX_ATT_RST      = 3'd3;
    localparam logic [3:0]  FAULT_PER_RST    = 4'd9;

    localparam logic        REG_MAX_ATT      = 1'b0;
    localparam logic        REG_FAULT_PER    = 1'b1;

    localparam logic        REQ_START        = 1'b0;
    localparam logic        REQ_RX_BYTE      = 1'b1;

    localparam logic [1:0]  KIND_BREAK       = 2'd0;
    localparam logic [1:0]  KIND_BYTE        = 2'd1;
    localparam logic [1:0]  KIND_FAIL        = 2'd2;
    localparam logic [1:0]  KIND_DONE        = 2'd3;

    localparam logic [1:0]  ST_OK            = 2'd0;
    localparam logic [1:0]  ST_BAD_ID        = 2'd1;
    localparam logic [1:0]  ST_EXHAUSTED     = 2'd2;

    localparam logic [7:0]  SYNC_BYTE        = 8'h55;
    localparam logic [1:0]  FORCED_PAR       = 2'b11;
    localparam logic [7:0]  CRC_POLY         = 8'hD5;
    localparam logic [7:0]  ID_MIN           = 8'd2;
    localparam logic [7:0]  ID_MAX           = 8'd59;

    typedef struct packed {
        logic       req_type;
        logic [7:0] slave_id;
        logic [7:0] rx_byte;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic [1:0] status;
        logic [7:0] data_byte;
        logic       checksum_bad;
        logic       crc_bad;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [RES_CNT_W-1:0]  cnt;
        t_res [MAX_RES-1:0]    res;
    } t_bundle;

    function automatic t_res mk_res(input logic [1:0] kind, input logic [7:0] tx,
                                    input logic [1:0] st, input logic [7:0] data,
                                    input logic cbad, input logic rbad);
        t_res r;
        r.kind         = kind;
        r.tx_byte      = tx;
        r.status       = st;
        r.data_byte    = data;
        r.checksum_bad = cbad;
        r.crc_bad      = rbad;
        r.last         = 1'b0;
        return r;
    endfunction

    // CRC-8 remainder of d0 then d1, generator 0x1D5
    function automatic logic [7:0] crc_rem(input logic [7:0] d0, input logic [7:0] d1);
        logic [8:0] rem;
        rem = {1'b0, d0};
        for (int i = 0; i < 8; i++) begin
            rem = {rem[7:0], d1[7-i]};
            if (rem[8]) begin
                rem = rem ^ {1'b0, CRC_POLY};
            end
        end
        return rem[7:0];
    endfunction

    // one's-complement style sum with a single end-around carry
    function automatic logic sum_ok(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
        logic [9:0] s;
        logic [8:0] r;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        r = {1'b0, s[7:0]} + {7'd0, s[9:8]};
        return r[7:0] == 8'hFF;
    endfunction

endpackage

### design/lmfe_core.sv
`timescale 1ns / 1ps

module lmfe_core import lmfe_pkg::*; #(
    parameter int RX_BYTES = RX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    input  logic [2:0]  i_max_att,
    input  logic [3:0]  i_fault_per,
    input  logic        i_free,
    output logic        o_push,
    output t_bundle     o_bundle
);

    localparam int RXW  = $clog2(RX_BYTES);
    localparam int ECHO = RX_BYTES - 3;

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_RX   = 1'b1;

    logic            r_in_vld;
    t_req            r_in;
    logic            r_phase,   n_phase;
    logic [5:0]      r_cur_id,  n_cur_id;
    logic [2:0]      r_att,     n_att;
    logic [3:0]      r_frame,   n_frame;
    logic [RXW-1:0]  r_rx_idx,  n_rx_idx;
    logic [7:0]      r_buf [2];

    logic            take;
    logic [5:0]      hdr_id;
    logic            forced;
    logic [4:0]      frame_inc;
    logic [7:0]      pid;
    logic [3:0]      frame_hdr;
    logic            cbad, rbad;
    logic [2:0]      att_inc, limit;
    t_res [MAX_RES-1:0]    res;
    logic [RES_CNT_W-1:0]  cnt;

    assign take       = r_in_vld && i_free;
    assign o_in_ready = !r_in_vld || take;
    assign o_push     = take;

    // header for the id that the frame will carry
    assign hdr_id    = (r_phase == PH_IDLE) ? r_in.slave_id[5:0] : r_cur_id;
    assign forced    = (i_fault_per != 4'd0) &&
                       (r_frame == ((i_fault_per == 4'd1) ? 4'd0 : 4'd1));
    assign frame_inc = {1'b0, r_frame} + 5'd1;
    assign frame_hdr = (i_fault_per == 4'd0) ? r_frame :
                       (frame_inc >= {1'b0, i_fault_per}) ? 4'd0 : frame_inc[3:0];
    assign pid       = {hdr_id, forced ? FORCED_PAR : {^hdr_id, 1'b0}};

    assign cbad    = !sum_ok(r_buf[0], r_buf[1], r_in.rx_byte);
    assign rbad    = crc_rem(r_buf[0], r_buf[1]) != 8'd0;
    assign att_inc = (r_att != 3'd7) ? r_att + 3'd1 : r_att;
    assign limit   = (i_max_att == 3'd0) ? 3'd1 : i_max_att;

    always_comb begin
        n_phase  = r_phase;
        n_cur_id = r_cur_id;
        n_att    = r_att;
        n_frame  = r_frame;
        n_rx_idx = r_rx_idx;
        cnt      = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = '0;
        end
        unique case (r_in.req_type)
            REQ_START: begin
                if (r_phase == PH_IDLE) begin
                    if (r_in.slave_id < ID_MIN || r_in.slave_id > ID_MAX) begin
                        res[0] = mk_res(KIND_DONE, 8'd0, ST_BAD_ID, 8'd0, 1'b0, 1'b0);
                        cnt    = RES_CNT_W'(1);
                    end else begin
                        n_cur_id = r_in.slave_id[5:0];
                        n_att    = 3'd0;
                        n_frame  = frame_hdr;
                        n_phase  = PH_RX;
                        n_rx_idx = '0;
                        res[0]   = mk_res(KIND_BREAK, 8'd0, ST_OK, 8'd0, 1'b0, 1'b0);
                        res[1]   = mk_res(KIND_BYTE, SYNC_BYTE, ST_OK, 8'd0, 1'b0, 1'b0);
                        res[2]   = mk_res(KIND_BYTE, pid, ST_OK, 8'd0, 1'b0, 1'b0);
                        cnt      = RES_CNT_W'(3);
                    end
                end
            end
            REQ_RX_BYTE: begin
                if (r_phase == PH_RX) begin
                    if (r_rx_idx != RXW'(RX_BYTES - 1)) begin
                        n_rx_idx = r_rx_idx + RXW'(1);
                    end else begin
                        n_rx_idx = '0;
                        if (!cbad && !rbad) begin
                            res[0]  = mk_res(KIND_DONE, 8'd0, ST_OK, r_buf[0], 1'b0, 1'b0);
                            cnt     = RES_CNT_W'(1);
                            n_phase = PH_IDLE;
                        end else begin
                            res[0] = mk_res(KIND_FAIL, 8'd0, ST_OK, r_buf[0], cbad, rbad);
                            n_att  = att_inc;
                            if (att_inc >= limit) begin
                                res[1]  = mk_res(KIND_DONE, 8'd0, ST_EXHAUSTED, 8'd0,
                                                 1'b0, 1'b0);
                                cnt     = RES_CNT_W'(2);
                                n_phase = PH_IDLE;
                            end else begin
                                n_frame = frame_hdr;
                                res[1]  = mk_res(KIND_BREAK, 8'd0, ST_OK, 8'd0, 1'b0, 1'b0);
                                res[2]  = mk_res(KIND_BYTE, SYNC_BYTE, ST_OK, 8'd0,
                                                 1'b0, 1'b0);
                                res[3]  = mk_res(KIND_BYTE, pid, ST_OK, 8'd0, 1'b0, 1'b0);
                                cnt     = RES_CNT_W'(4);
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < MAX_RES; k++) begin
            res[k].last = (RES_CNT_W'(k + 1) == cnt);
        end
    end

    assign o_bundle.cnt = cnt;
    assign o_bundle.res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_phase  <= PH_IDLE;
            r_cur_id <= '0;
            r_att    <= '0;
            r_frame  <= '0;
            r_rx_idx <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (take) begin
                r_phase  <= n_phase;
                r_cur_id <= n_cur_id;
                r_att    <= n_att;
                r_frame  <= n_frame;
                r_rx_idx <= n_rx_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (take && r_in.req_type == REQ_RX_BYTE && r_phase == PH_RX) begin
            if (r_rx_idx == RXW'(ECHO)) begin
                r_buf[0] <= r_in.rx_byte;
            end
            if (r_rx_idx == RXW'(ECHO + 1)) begin
                r_buf[1] <= r_in.rx_byte;
            end
        end
    end

endmodule

### design/lmfe_drain.sv
`timescale 1ns / 1ps

module lmfe_drain import lmfe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_bundle  i_bundle,
    output logic     o_free,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_res     o_out_data
);

    t_res                  r_ent [MAX_RES];
    logic [RES_CNT_W-1:0]  r_rem;
    logic [RES_IDX_W-1:0]  r_idx;
    logic                  r_out_vld;
    t_res                  r_out;
    logic                  load;

    assign load        = (r_rem != '0) && (!r_out_vld || i_out_ready);
    assign o_free      = (r_rem == '0) || (r_rem == RES_CNT_W'(1) && load);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_push) begin
                r_rem <= i_bundle.cnt;
                r_idx <= '0;
            end else if (load) begin
                r_rem <= r_rem - RES_CNT_W'(1);
                r_idx <= r_idx + RES_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_ent[r_idx];
        end
        if (i_push) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_ent[k] <= i_bundle.res[k];
            end
        end
    end

endmodule

### design/lin_master_frame_engine_unit.sv
`timescale 1ns / 1ps
// channel   | direction | handshake                 | payload
// request   | in        | i_in_valid / o_in_ready   | i_in_data   (t_req)
// result    | out       | o_out_valid / i_out_ready | o_out_data  (t_res)
// config    | in        | APB psel/penable/pready   | paddr, pwdata, prdata
//
// A request is held in an input register and turned combinationally into
// a bundle of up to four result words; the bundle drains one word a cycle
// through the output register while the output is not stalled. The next
// request waits in the input register until the drain is empty or loading
// its last word. Synchronous active-low reset clears the valid flags and the
// frame state; a stalled output holds the word.

module lin_master_frame_engine_unit import lmfe_pkg::*; #(
    parameter int RX_BYTES = RX_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_req         i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_res         o_out_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [2:0]  r_max_att_q;
    logic [3:0]  r_fault_per;
    logic        reg_idx;
    logic        wr;
    logic        free;
    logic        push;
    t_bundle     bundle;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr      = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_MAX_ATT:   prdata = {29'd0, r_max_att_q};
            REG_FAULT_PER: prdata = {28'd0, r_fault_per};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_att_q <= MAX_ATT_RST;
            r_fault_per <= FAULT_PER_RST;
        end else if (wr) begin
            if (reg_idx == REG_MAX_ATT) begin
                r_max_att_q <= pwdata[2:0];
            end
            if (reg_idx == REG_FAULT_PER) begin
                r_fault_per <= pwdata[3:0];
            end
        end
    end

    lmfe_core #(
        .RX_BYTES (RX_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_max_att   (r_max_att_q),
        .i_fault_per (r_fault_per),
        .i_free      (free),
        .o_push      (push),
        .o_bundle    (bundle)
    );

    lmfe_drain u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_bundle    (bundle),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### design/lmfe_checker.sv
`timescale 1ns / 1ps

module lmfe_checker import lmfe_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         o_in_ready,
    input  t_req         i_in_data,
    input  logic         o_out_valid,
    input  logic         i_out_ready,
    input  t_res         o_out_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic [31:0]  prdata,
    input  logic         pready
);

    logic wr;
    assign wr = psel && penable && pwrite && pready;

    // a waiting request word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("request word changed while waiting");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed under stall");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // break is always followed at once by the sync byte
    a_brk_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.kind == KIND_BREAK
        |=> o_out_valid && o_out_data.kind == KIND_BYTE &&
            o_out_data.tx_byte == SYNC_BYTE)
        else $error("break not followed by sync byte");

    a_cfg_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(wr) && $past(i_rst_n) && paddr[2] == $past(paddr[2])
        |-> prdata == ($past(paddr[2]) ? {28'd0, $past(pwdata[3:0])}
                                       : {29'd0, $past(pwdata[2:0])}))
        else $error("register readback mismatch");

endmodule

bind lin_master_frame_engine_unit lmfe_checker u_lmfe_checker (.*);

### tb/lin_master_frame_engine_unit_test.sv
`timescale 1ns / 1ps

module lin_master_frame_engine_unit_test;
    import lmfe_pkg::*;

    typedef struct packed {
        logic             receiving;
        logic [5:0]       id;
        logic [2:0]       tries;
        logic [3:0]       frame_no;
        logic [2:0]       idx;
        logic [2:0][7:0]  rxb;
    } t_engine;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_ready;
    t_req         i_in_data;
    logic         o_out_valid;
    logic         i_out_ready;
    t_res         o_out_data;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    lin_master_frame_engine_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    logic [2:0]  cfg_max_att = MAX_ATT_RST;
    logic [3:0]  cfg_period  = FAULT_PER_RST;

    t_engine     eng  = '0;
    t_engine     plan = '0;

    t_req        pending_reqs[$];
    t_res        expected_words[$];
    t_res        held_word;
    bit          have_held = 1'b0;

    int          mismatches    = 0;
    int          reqs_accepted = 0;
    int          words_checked = 0;
    int          cfg_writes    = 0;
    int          burst_left    = 0;
    int          gap_left      = 0;
    int          stall_left    = 0;
    logic [15:0] stall_pat     = 16'hFFFF;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("%0t timeout", $realtime);
        $display("[lin_master_frame_engine_unit] ERROR");
        $finish;
    end

    function automatic logic [7:0] lin_crc_remainder(input logic [7:0] d0, input logic [7:0] d1);
        logic [8:0] rem;
        int         i;
        rem = {1'b0, d0};
        for (i = 7; i >= 0; i--) begin
            rem = {rem[7:0], d1[i]};
            if (rem[8]) begin
                rem[7:0] = rem[7:0] ^ 8'hD5;
            end
        end
        return rem[7:0];
    endfunction

    function automatic bit sum_passes(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
        int s;
        int r;
        s = a + b + c;
        r = (s & 8'hFF) + (s >> 8);
        return (r & 8'hFF) == 8'hFF;
    endfunction

    function automatic t_res make_word(input logic [1:0] k, input logic [7:0] tx,
                                       input logic [1:0] st, input logic [7:0] d,
                                       input logic cb, input logic rb);
        t_res w;
        w.kind         = k;
        w.tx_byte      = tx;
        w.status       = st;
        w.data_byte    = d;
        w.checksum_bad = cb;
        w.crc_bad      = rb;
        w.last         = 1'b0;
        return w;
    endfunction

    // the final word of a request carries last
    function automatic void stage_word(input t_res w);
        if (have_held) begin
            expected_words.push_back(held_word);
        end
        held_word = w;
        have_held = 1'b1;
    endfunction

    function automatic void close_words();
        if (have_held) begin
            held_word.last = 1'b1;
            expected_words.push_back(held_word);
            have_held = 1'b0;
        end
    endfunction

    function automatic t_engine emit_header_words(input t_engine s, input bit rec);
        bit         forced;
        int         p;
        logic [7:0] pid;
        forced = 1'b0;
        p = cfg_period;
        if (p != 0) begin
            forced = (s.frame_no == (1 % p));
            s.frame_no = (s.frame_no + 1 >= p) ? 4'd0 : s.frame_no + 4'd1;
        end
        pid = forced ? {s.id, FORCED_PAR} : {s.id, ^s.id, 1'b0};
        if (rec) begin
            stage_word(make_word(KIND_BREAK, 8'h00, ST_OK, 8'h00, 1'b0, 1'b0));
            stage_word(make_word(KIND_BYTE, SYNC_BYTE, ST_OK, 8'h00, 1'b0, 1'b0));
            stage_word(make_word(KIND_BYTE, pid, ST_OK, 8'h00, 1'b0, 1'b0));
        end
        s.receiving = 1'b1;
        s.idx = 3'd0;
        return s;
    endfunction

    function automatic t_engine step_frame_engine(input t_engine s, input t_req r,
                                                  input bit rec);
        int   pos;
        int   limit;
        logic cbad;
        logic rbad;
        if (r.req_type == REQ_START) begin
            if (s.receiving) begin
                return s;
            end
            if (r.slave_id < ID_MIN || r.slave_id > ID_MAX) begin
                if (rec) begin
                    stage_word(make_word(KIND_DONE, 8'h00, ST_BAD_ID, 8'h00, 1'b0, 1'b0));
                end
            end else begin
                s.id = r.slave_id[5:0];
                s.tries = 3'd0;
                s = emit_header_words(s, rec);
            end
        end else begin
            if (!s.receiving) begin
                return s;
            end
            pos = s.idx;
            // echo bytes are dropped, the last three are kept
            if (pos >= RX_BYTES_DEF - 3 && pos < RX_BYTES_DEF) begin
                s.rxb[pos - (RX_BYTES_DEF - 3)] = r.rx_byte;
            end
            if (pos + 1 < RX_BYTES_DEF) begin
                s.idx = 3'(pos + 1);
                return s;
            end
            s.idx = 3'd0;
            cbad = !sum_passes(s.rxb[0], s.rxb[1], s.rxb[2]);
            rbad = lin_crc_remainder(s.rxb[0], s.rxb[1]) != 8'h00;
            if (!cbad && !rbad) begin
                if (rec) begin
                    stage_word(make_word(KIND_DONE, 8'h00, ST_OK, s.rxb[0], 1'b0, 1'b0));
                end
                s.receiving = 1'b0;
            end else begin
                if (rec) begin
                    stage_word(make_word(KIND_FAIL, 8'h00, ST_OK, s.rxb[0], cbad, rbad));
                end
                if (s.tries != 3'd7) begin
                    s.tries = s.tries + 3'd1;
                end
                limit = (cfg_max_att == 3'd0) ? 1 : cfg_max_att;
                if (s.tries >= limit) begin
                    if (rec) begin
                        stage_word(make_word(KIND_DONE, 8'h00, ST_EXHAUSTED, 8'h00,
                                             1'b0, 1'b0));
                    end
                    s.receiving = 1'b0;
                end else begin
                    s = emit_header_words(s, rec);
                end
            end
        end
        if (rec) begin
            close_words();
        end
        return s;
    endfunction

    // echo, echo, data, CRC, checksum
    function automatic logic [4:0][7:0] make_reply(input logic [7:0] d, input bit sum_good,
                                                   input bit crc_good);
        logic [4:0][7:0] f;
        logic [7:0]      c;
        logic [7:0]      k;
        int              v;
        c = 8'h00;
        k = 8'h00;
        for (v = 0; v < 256; v++) begin
            if (lin_crc_remainder(d, 8'(v)) == 8'h00) begin
                c = 8'(v);
            end
        end
        if (!crc_good) begin
            c = c ^ 8'($urandom_range(1, 255));
        end
        for (v = 0; v < 256; v++) begin
            if (sum_passes(d, c, 8'(v))) begin
                k = 8'(v);
            end
        end
        if (!sum_good) begin
            k = k + 8'($urandom_range(2, 250));
        end
        f[0] = SYNC_BYTE;
        f[1] = 8'($urandom);
        f[2] = d;
        f[3] = c;
        f[4] = k;
        return f;
    endfunction

    function automatic bit queue_req(input logic t, input logic [7:0] id, input logic [7:0] b);
        t_req r;
        bit   counted;
        r.req_type = t;
        r.slave_id = id;
        r.rx_byte  = b;
        counted = (t == REQ_START) ? !plan.receiving : plan.receiving;
        plan = step_frame_engine(plan, r, 1'b0);
        pending_reqs.push_back(r);
        return counted;
    endfunction

    task automatic queue_reply(input logic [4:0][7:0] f);
        int  i;
        bit  dummy;
        for (i = 0; i < 5; i++) begin
            dummy = queue_req(REQ_RX_BYTE, 8'($urandom), f[i]);
        end
    endtask

    task automatic gen_traffic(input int n);
        int              made;
        int              roll;
        int              outcome;
        logic            t;
        logic [7:0]      id;
        logic [7:0]      b;
        logic [4:0][7:0] reply;
        made = 0;
        reply = '0;
        while (made < n) begin
            roll = $urandom_range(0, 99);
            t  = 1'($urandom);
            id = 8'($urandom);
            b  = 8'($urandom);
            if (!plan.receiving) begin
                if (roll < 70) begin
                    t = REQ_START;
                    case ($urandom_range(0, 9))
                        0:       id = ID_MIN;
                        1:       id = ID_MAX;
                        default: id = 8'($urandom_range(ID_MIN, ID_MAX));
                    endcase
                end else if (roll < 82) begin
                    t  = REQ_START;
                    id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1))
                                                     : 8'($urandom_range(60, 255));
                end else if (roll < 88) begin
                    t = REQ_RX_BYTE;
                end
            end else begin
                if (plan.idx == 3'd0) begin
                    outcome = $urandom_range(0, 99);
                    reply = make_reply(8'($urandom), outcome < 40 || outcome >= 80 && 1'b0
                                       || (outcome >= 60 && outcome < 80),
                                       outcome < 60);
                end
                if (roll < 88) begin
                    t = REQ_RX_BYTE;
                    b = reply[plan.idx];
                end else if (roll < 93) begin
                    t = REQ_START;
                end else begin
                    t = REQ_RX_BYTE;
                end
            end
            if (queue_req(t, id, b)) begin
                made++;
            end
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] val);
        logic [31:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_MAX_ATT) begin
            cfg_max_att = val[2:0];
            want = {29'd0, val[2:0]};
        end else begin
            cfg_period = val[3:0];
            want = {28'd0, val[3:0]};
        end
        cfg_writes++;
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t readback reg %0d: expected %h got %h", $realtime, idx, want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_setting(input logic [2:0] att, input logic [3:0] per, input int n);
        drain();
        cfg_write(REG_MAX_ATT, {29'($urandom), att});
        cfg_write(REG_FAULT_PER, {28'($urandom), per});
        gen_traffic(n);
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                eng = step_frame_engine(eng, i_in_data, 1'b1);
                reqs_accepted++;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold word until taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                i_in_data  <= nxt;
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            stall_left = 64;
        end
        stall_left--;
        i_out_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_data;
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word: expected none, got %h", $realtime, got);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
                    got.status !== want.status || got.data_byte !== want.data_byte ||
                    got.checksum_bad !== want.checksum_bad || got.crc_bad !== want.crc_bad ||
                    got.last !== want.last) begin
                    $display("%0t word mismatch: expected k%0d tx %h st%0d d %h cs%b crc%b l%b",
                             $realtime, want.kind, want.tx_byte, want.status, want.data_byte,
                             want.checksum_bad, want.crc_bad, want.last);
                    $display("%0t                got      k%0d tx %h st%0d d %h cs%b crc%b l%b",
                             $realtime, got.kind, got.tx_byte, got.status, got.data_byte,
                             got.checksum_bad, got.crc_bad, got.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        bit dummy;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle byte, bad IDs, normal then forced header, start mid-frame, all failure kinds
        dummy = queue_req(REQ_RX_BYTE, 8'h00, 8'hA5);
        dummy = queue_req(REQ_START, 8'h00, 8'hFF);
        dummy = queue_req(REQ_START, 8'h01, 8'h00);
        dummy = queue_req(REQ_START, 8'd60, 8'h00);
        dummy = queue_req(REQ_START, 8'hFF, 8'h00);
        dummy = queue_req(REQ_START, ID_MIN, 8'h00);
        dummy = queue_req(REQ_START, ID_MAX, 8'hFF);
        queue_reply(make_reply(8'h00, 1'b1, 1'b1));
        dummy = queue_req(REQ_START, ID_MAX, 8'h00);
        queue_reply(make_reply(8'hFF, 1'b0, 1'b1));
        queue_reply(make_reply(8'h5A, 1'b1, 1'b0));
        queue_reply(make_reply(8'hA5, 1'b0, 1'b0));

        gen_traffic(60);
        run_setting(3'd1, 4'd1, 60);
        run_setting(3'd7, 4'd15, 60);
        run_setting(3'd0, 4'd2, 60);
        run_setting(3'd5, 4'd0, 60);
        run_setting(3'd2, 4'd9, 60);
        drain();
        if (have_held || expected_words.size() != 0) begin
            $display("%0t %0d words never arrived", $realtime, expected_words.size());
            mismatches++;
        end

        $display("%0d requests taken, %0d result words checked, %0d register writes",
                 reqs_accepted, words_checked, cfg_writes);
        $display("attempt limits 0, 1, 2, 3, 5, 7 and fault periods 0, 1, 2, 9, 15 exercised");
        if (mismatches == 0) begin
            $display("[lin_master_frame_engine_unit] OK");
        end else begin
            $display("[lin_master_frame_engine_unit] ERROR");
        end
        $finish;
    end

endmodule
